[hdl/pv1hp_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// pv1hp_pkg: shared types and constants of the PROXY v1 header parser
// Holds the tag bytes, the character codes and the scanner status type.
// ============================================================================
package pv1hp_pkg;

  localparam int unsigned MAX_CHUNK_BYTES_DEF = 4096;
  localparam int unsigned HDR_LEN_W = 13;
  localparam int unsigned ADDR_W = 32;

  localparam int unsigned PROXY_TAG_LEN = 6;
  localparam int unsigned TCP4_TAG_LEN = 5;
  localparam int unsigned SCAN_FIRST_POS = 11;
  localparam int unsigned SCAN_LAST_POS = 25;

  localparam logic [7:0] PROXY_TAG [PROXY_TAG_LEN] = '{8'h50, 8'h52, 8'h4f, 8'h58, 8'h59, 8'h20};
  localparam logic [7:0] TCP4_TAG [TCP4_TAG_LEN] = '{8'h54, 8'h43, 8'h50, 8'h34, 8'h20};

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_DOT = 8'h2e;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [2:0] ADDR_DOTS = 3'd3;

  typedef struct packed {
    logic step;
    logic clear;
  } scan_ctrl_t;

  typedef struct packed {
    logic other_char;
    logic format_ok;
    logic [2:0] dot_count;
    logic [1:0] octet_digits;
    logic [7:0] octet_low;
    logic [23:0] shift_low;
  } scan_status_t;

endpackage

[hdl/pv1hp_addr_scan.sv]
`timescale 1ns / 1ps
// ============================================================================
// pv1hp_addr_scan: dotted-decimal IPv4 scanner
// Keeps the octet and dot state and reports the updated state for each byte.
// ============================================================================
module pv1hp_addr_scan (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pv1hp_pkg::scan_ctrl_t   ctrl_i,
  input  logic [7:0]              data_byte_i,
  output pv1hp_pkg::scan_status_t status_o
);
  import pv1hp_pkg::*;

  logic        ok_q, ok_d;
  logic [2:0]  dots_q, dots_d;
  logic [8:0]  val_q, val_d;
  logic [1:0]  digits_q, digits_d;
  logic [23:0] shift_q, shift_d;
  logic        is_digit, is_dot;
  logic [3:0]  digit;
  logic [11:0] prod;

  assign is_digit = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
  assign is_dot = (data_byte_i == CHAR_DOT);
  assign digit = 4'(data_byte_i - CHAR_ZERO);
  assign prod = {val_q, 3'b000} + {2'b00, val_q, 1'b0} + {8'h00, digit};

  always_comb begin
    ok_d = ok_q;
    dots_d = dots_q;
    val_d = val_q;
    digits_d = digits_q;
    shift_d = shift_q;
    if (ctrl_i.step) begin
      if (is_digit) begin
        if (digits_q == 2'd0) begin
          val_d = {5'd0, digit};
          digits_d = 2'd1;
        end else begin
          if ((val_q == 9'd0) || (digits_q == 2'd3)) begin
            ok_d = 1'b0;
          end
          if (prod > 12'd255) begin
            ok_d = 1'b0;
            val_d = 9'd256;
          end else begin
            val_d = prod[8:0];
          end
          if (digits_q != 2'd3) begin
            digits_d = digits_q + 2'd1;
          end
        end
      end else if (is_dot) begin
        if (digits_q == 2'd0) begin
          ok_d = 1'b0;
        end
        shift_d = {shift_q[15:0], val_q[7:0]};
        if (dots_q != 3'd7) begin
          dots_d = dots_q + 3'd1;
        end
        val_d = 9'd0;
        digits_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b1;
      dots_q <= '0;
      val_q <= '0;
      digits_q <= '0;
      shift_q <= '0;
    end else if (ctrl_i.clear) begin
      ok_q <= 1'b1;
      dots_q <= '0;
      val_q <= '0;
      digits_q <= '0;
      shift_q <= '0;
    end else begin
      ok_q <= ok_d;
      dots_q <= dots_d;
      val_q <= val_d;
      digits_q <= digits_d;
      shift_q <= shift_d;
    end
  end

  assign status_o.other_char = !is_digit && !is_dot;
  assign status_o.format_ok = ok_d;
  assign status_o.dot_count = dots_d;
  assign status_o.octet_digits = digits_d;
  assign status_o.octet_low = val_d[7:0];
  assign status_o.shift_low = shift_d;

endmodule

[hdl/proxy_v1_header_parser_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// proxy_v1_header_parser_unit: PROXY protocol v1 header parser
// Parses the first chunk of a connection, one byte per beat, and delivers
// header length and TCP4 source address when the chunk's last byte arrives.
// ============================================================================
// Throughput: one byte beat per cycle while the input is not stalled, including the last byte.
// Result: the result beat is valid in the cycle after the last byte is accepted,
//   set by the single result register behind the per-byte update logic.
// Input stall is raised only while a result is held and the output is stalled.
// Reset (rst_ni low, asynchronous) clears the parse state and drops out_valid_o.
module proxy_v1_header_parser_unit #(
  parameter int unsigned MAX_CHUNK_BYTES = pv1hp_pkg::MAX_CHUNK_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_byte_i,
  input  logic                              parse_enable_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pv1hp_pkg::HDR_LEN_W-1:0]   header_length_o,
  output logic [pv1hp_pkg::ADDR_W-1:0]      real_ipv4_o,
  output logic                              ip_valid_o
);
  import pv1hp_pkg::*;

  // The position counter must be able to hold MAX_CHUNK_BYTES itself.
  localparam int unsigned POS_W = $clog2(MAX_CHUNK_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHUNK_BYTES);

  logic             accept;
  logic             in_range;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       flags_q, flags_d;
  logic             active_q, active_d;
  logic             prev_cr_q, prev_cr_d;
  logic [POS_W-1:0] crlf_q, crlf_d;
  logic             zero_q, zero_d;
  logic [2:0]       proxy_idx;
  logic [2:0]       tcp_idx;
  logic [3:0]       tcp_off;
  scan_ctrl_t       scan_ctrl;
  scan_status_t     scan_st;

  logic                 out_valid_q;
  logic [HDR_LEN_W-1:0] hdr_q, hdr_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic                 ipv_q, ipv_d;
  logic                 proxy_ok;

  // A beat can always be taken unless a held result cannot leave this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  // Bytes past the chunk limit only contribute their last-byte mark.
  assign in_range = (pos_q < POS_MAX);

  assign proxy_idx = pos_q[2:0];
  assign tcp_off = pos_q[3:0] - 4'd6;
  assign tcp_idx = tcp_off[2:0];

  // The address scanner steps only on scanned positions while the scan is live.
  assign scan_ctrl.step = accept && in_range && active_q
                       && (pos_q >= POS_W'(SCAN_FIRST_POS))
                       && (pos_q <= POS_W'(SCAN_LAST_POS));
  assign scan_ctrl.clear = accept && last_byte_i;

  pv1hp_addr_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .data_byte_i(data_byte_i),
    .status_o   (scan_st)
  );

  // Per-byte update of prefix match, scan window and CRLF search.
  always_comb begin
    pos_d = pos_q;
    flags_d = flags_q;
    active_d = active_q;
    prev_cr_d = prev_cr_q;
    crlf_d = crlf_q;
    zero_d = zero_q;
    if (accept && in_range) begin
      if (pos_q < POS_W'(PROXY_TAG_LEN)) begin
        if (data_byte_i != PROXY_TAG[proxy_idx]) begin
          flags_d[0] = 1'b0;
        end
      end else if (pos_q < POS_W'(SCAN_FIRST_POS)) begin
        if (data_byte_i != TCP4_TAG[tcp_idx]) begin
          flags_d[1] = 1'b0;
        end
        // The scan opens after the space that ends "TCP4 " if both tags held.
        if (pos_q == POS_W'(SCAN_FIRST_POS - 1)) begin
          active_d = (flags_d == 2'b11);
        end
      end else if (pos_q <= POS_W'(SCAN_LAST_POS)) begin
        if (scan_ctrl.step && scan_st.other_char) begin
          active_d = 1'b0;
        end
        if (pos_q == POS_W'(SCAN_LAST_POS)) begin
          active_d = 1'b0;
        end
      end

      // The first CRLF fixes the header length; a NUL byte ends the search.
      if ((crlf_q == '0) && !zero_q) begin
        if (data_byte_i == CHAR_NUL) begin
          zero_d = 1'b1;
        end else if (prev_cr_q && (data_byte_i == CHAR_LF)) begin
          crlf_d = pos_q + POS_W'(1);
        end
      end
      prev_cr_d = (data_byte_i == CHAR_CR);
      pos_d = pos_q + POS_W'(1);
    end
  end

  // The result is built from the state as updated by the last byte itself.
  assign proxy_ok = flags_d[0] && (pos_d >= POS_W'(PROXY_TAG_LEN));

  always_comb begin
    hdr_d = '0;
    addr_d = '0;
    ipv_d = 1'b0;
    if (parse_enable_i && proxy_ok) begin
      hdr_d = HDR_LEN_W'(crlf_d);
      if (flags_d[1] && (pos_d >= POS_W'(SCAN_LAST_POS + 1)) && scan_st.format_ok
          && (scan_st.dot_count == ADDR_DOTS) && (scan_st.octet_digits != 2'd0)) begin
        addr_d = {scan_st.shift_low, scan_st.octet_low};
        ipv_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      flags_q <= 2'b11;
      active_q <= 1'b0;
      prev_cr_q <= 1'b0;
      crlf_q <= '0;
      zero_q <= 1'b0;
    end else if (accept && last_byte_i) begin
      // The last byte of a chunk starts the state over for the next chunk.
      pos_q <= '0;
      flags_q <= 2'b11;
      active_q <= 1'b0;
      prev_cr_q <= 1'b0;
      crlf_q <= '0;
      zero_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      flags_q <= flags_d;
      active_q <= active_d;
      prev_cr_q <= prev_cr_d;
      crlf_q <= crlf_d;
      zero_q <= zero_d;
    end
  end

  // Result register: loads on a last byte, empties when the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      hdr_q <= hdr_d;
      addr_q <= addr_d;
      ipv_q <= ipv_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign header_length_o = hdr_q;
  assign real_ipv4_o = addr_q;
  assign ip_valid_o = ipv_q;

`ifndef SYNTHESIS
  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a held result");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_byte_i) |=> out_valid_o)
    else $error("last byte accepted but no result presented");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_byte_i) |=> (pos_q == '0) && (flags_q == 2'b11))
    else $error("parse state not restarted after last byte");

  a_no_addr_without_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ip_valid_o) |-> (real_ipv4_o == '0))
    else $error("address reported without valid flag");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_MAX)
    else $error("byte position beyond chunk limit");
`endif

endmodule

[test/pv1hp_result_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// pv1hp_result_checker: result checker for the PROXY v1 header parser
// Watches the byte and result channels, runs its own byte-by-byte parse of
// each chunk and compares every result beat with the oldest prediction.
// ============================================================================
module pv1hp_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            last_byte_i,
  input  logic                            parse_enable_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [pv1hp_pkg::HDR_LEN_W-1:0] header_length_i,
  input  logic [pv1hp_pkg::ADDR_W-1:0]    real_ipv4_i,
  input  logic                            ip_valid_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import pv1hp_pkg::*;

  typedef struct packed {
    logic [HDR_LEN_W-1:0] header_length;
    logic [ADDR_W-1:0]    real_ipv4;
    logic                 ip_valid;
  } header_info_t;

  // Parse state of the chunk in progress.
  int unsigned          byte_pos;
  logic                 proxy_match;
  logic                 tcp4_match;
  logic                 scan_on;
  logic [2:0]           dots;
  logic [8:0]           oct_val;
  logic [1:0]           oct_digits;
  logic [ADDR_W-1:0]    addr_acc;
  logic                 fmt_ok;
  logic                 prev_cr;
  logic [HDR_LEN_W-1:0] crlf_end;
  logic                 nul_seen;

  header_info_t expected_headers[$];
  int errors = 0;

  function automatic void clear_parse();
    byte_pos    = 0;
    proxy_match = 1'b1;
    tcp4_match  = 1'b1;
    scan_on     = 1'b0;
    dots        = '0;
    oct_val     = '0;
    oct_digits  = '0;
    addr_acc    = '0;
    fmt_ok      = 1'b1;
    prev_cr     = 1'b0;
    crlf_end    = '0;
    nul_seen    = 1'b0;
  endfunction

  function automatic void scan_addr_char(input logic [7:0] c);
    int unsigned v;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      if (oct_digits == 2'd0) begin
        oct_val    = 9'(c - CHAR_ZERO);
        oct_digits = 2'd1;
      end else begin
        // A leading zero or a fourth digit spoils the octet.
        if (oct_val == 9'd0 || oct_digits == 2'd3) fmt_ok = 1'b0;
        v = oct_val * 10 + (c - CHAR_ZERO);
        if (v > 255) begin
          fmt_ok  = 1'b0;
          oct_val = 9'd256;
        end else begin
          oct_val = v[8:0];
        end
        if (oct_digits != 2'd3) oct_digits = oct_digits + 2'd1;
      end
    end else if (c == CHAR_DOT) begin
      if (oct_digits == 2'd0) fmt_ok = 1'b0;
      addr_acc   = {addr_acc[ADDR_W-9:0], oct_val[7:0]};
      if (dots != 3'd7) dots = dots + 3'd1;
      oct_val    = '0;
      oct_digits = '0;
    end else begin
      scan_on = 1'b0;
    end
  endfunction

  function automatic void advance_parse(input logic [7:0] c);
    int unsigned p;
    if (byte_pos < MAX_CHUNK_BYTES_DEF) begin
      p = byte_pos;
      if (p < PROXY_TAG_LEN) begin
        if (c != PROXY_TAG[p]) proxy_match = 1'b0;
      end else if (p < SCAN_FIRST_POS) begin
        if (c != TCP4_TAG[p - PROXY_TAG_LEN]) tcp4_match = 1'b0;
        if (p == SCAN_FIRST_POS - 1) scan_on = proxy_match && tcp4_match;
      end else if (p <= SCAN_LAST_POS) begin
        if (scan_on) scan_addr_char(c);
        if (p == SCAN_LAST_POS) scan_on = 1'b0;
      end
      // The CRLF search ends for good at the first zero byte.
      if (crlf_end == '0 && !nul_seen) begin
        if (c == CHAR_NUL) nul_seen = 1'b1;
        else if (prev_cr && c == CHAR_LF) crlf_end = HDR_LEN_W'(p + 1);
      end
      prev_cr  = (c == CHAR_CR);
      byte_pos = p + 1;
    end
  endfunction

  function automatic header_info_t header_result(input logic enable);
    header_info_t r;
    logic         hdr_ok;
    r      = '0;
    hdr_ok = proxy_match && byte_pos >= PROXY_TAG_LEN;
    if (enable && hdr_ok) begin
      r.header_length = crlf_end;
      if (tcp4_match && byte_pos > SCAN_LAST_POS && fmt_ok && dots == ADDR_DOTS &&
          oct_digits != 2'd0) begin
        r.real_ipv4 = {addr_acc[ADDR_W-9:0], oct_val[7:0]};
        r.ip_valid  = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [ADDR_W-1:0] want,
                                      input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    header_info_t want;
    if (!rst_ni) begin
      clear_parse();
      expected_headers.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        advance_parse(data_byte_i);
        if (last_byte_i) begin
          expected_headers.insert(expected_headers.size(), header_result(parse_enable_i));
          clear_parse();
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_headers.size() == 0) begin
          errors++;
          $display("t=%0t unexpected result beat: expected none, actual len=%0d addr=%0h v=%0b",
                   $time, header_length_i, real_ipv4_i, ip_valid_i);
        end else begin
          want = expected_headers.pop_front();
          check_field("header_length", ADDR_W'(want.header_length), ADDR_W'(header_length_i));
          check_field("real_ipv4", want.real_ipv4, real_ipv4_i);
          check_field("ip_valid", ADDR_W'(want.ip_valid), ADDR_W'(ip_valid_i));
        end
      end
      pending_o <= expected_headers.size();
    end
    fail_count_o <= errors;
  end

endmodule

[test/tb_proxy_v1_header_parser_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_proxy_v1_header_parser_unit: testbench of the PROXY v1 header parser
// Sends directed and random connection chunks byte by byte under random
// idling on both channels; a separate checker predicts and compares results.
// ============================================================================
module tb_proxy_v1_header_parser_unit;
  import pv1hp_pkg::*;

  localparam int unsigned RAND_BYTES  = 930;
  localparam int unsigned RAND_CHUNKS = 12;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = '0;
  logic                 last_byte = 1'b0;
  logic                 parse_enable = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [HDR_LEN_W-1:0] header_length;
  logic [ADDR_W-1:0]    real_ipv4;
  logic                 ip_valid;

  int fail_count;
  int pending;

  // Idle rates in percent for the byte sender and the result receiver.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // The long receiver hold-off: requested once by the stimulus, counted below.
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  logic [7:0]  chunk_bytes[$];
  int unsigned rand_bytes = 0;
  int unsigned rand_chunks = 0;

  always #5 clk = ~clk;

  proxy_v1_header_parser_unit DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .parse_enable_i (parse_enable),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .header_length_o(header_length),
    .real_ipv4_o    (real_ipv4),
    .ip_valid_o     (ip_valid)
  );

  pv1hp_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .parse_enable_i (parse_enable),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .header_length_i(header_length),
    .real_ipv4_i    (real_ipv4),
    .ip_valid_i     (ip_valid),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Result receiver. Stalls at random at the current rate, except during the
  // single long hold-off, which it counts down itself. While the hold lasts,
  // the parser can park only one result, so its byte input must stall too.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    chunk_bytes.insert(chunk_bytes.size(), b);
  endfunction

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic put_crlf();
    add_byte(CHAR_CR);
    add_byte(CHAR_LF);
  endtask

  // Sends the queued chunk, one beat per byte, with the last beat marked.
  // The enable flag only matters on the last beat; the other beats carry
  // random values so that the flag toggles freely.
  task automatic send_chunk(input logic en);
    int unsigned n;
    n = chunk_bytes.size();
    for (int unsigned i = 0; i < n; i++) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid     <= 1'b1;
      data_byte    <= chunk_bytes[i];
      last_byte    <= (i == n - 1);
      parse_enable <= (i == n - 1) ? en : 1'($urandom_range(1));
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    chunk_bytes.delete();
  endtask

  // One octet of address text; most are plain, some break the strict rules.
  function automatic string octet_text();
    case ($urandom_range(19))
      0: return "";
      1: return $sformatf("0%0d", $urandom_range(99));
      2: return $sformatf("%0d", $urandom_range(256, 999));
      3: return $sformatf("%0d", $urandom_range(1000, 99999));
      4: return "0";
      5: return "255";
      default: return $sformatf("%0d", $urandom_range(255));
    endcase
  endfunction

  function automatic string addr_text();
    string       s;
    int unsigned dots_n;
    s      = "";
    dots_n = ($urandom_range(99) < 85) ? 3 : $urandom_range(5);
    for (int unsigned k = 0; k <= dots_n; k++) begin
      if (k != 0) s = {s, "."};
      s = {s, octet_text()};
    end
    return s;
  endfunction

  // Mostly well-formed headers with random content; a few broken prefixes,
  // other protocols, stray zero bytes or CRs, corrupted bytes, truncated
  // chunks and plain noise.
  task automatic build_random_chunk();
    int unsigned r;
    int unsigned cut;
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 40)) add_byte(8'($urandom_range(255)));
      return;
    end
    if (r < 12) put_text("PROXZ ");
    else put_text("PROXY ");
    case ($urandom_range(19))
      0: put_text("TCP6 ");
      1: put_text("UNKNOWN");
      2: put_text("TCP4");
      default: put_text("TCP4 ");
    endcase
    put_text(addr_text());
    put_text($sformatf(" 10.%0d.0.1 %0d %0d", $urandom_range(255), $urandom_range(65535),
                       $urandom_range(65535)));
    case ($urandom_range(19))
      0: add_byte(CHAR_NUL);
      1: add_byte(CHAR_CR);
      default: ;
    endcase
    if ($urandom_range(9) != 0) put_crlf();
    repeat ($urandom_range(6)) begin
      case ($urandom_range(7))
        0: add_byte(CHAR_CR);
        1: add_byte(CHAR_LF);
        2: add_byte(CHAR_NUL);
        default: add_byte(8'($urandom_range(255)));
      endcase
    end
    if ($urandom_range(9) == 0)
      chunk_bytes[$urandom_range(chunk_bytes.size() - 1)] = 8'($urandom_range(255));
    if ($urandom_range(6) == 0) begin
      cut = $urandom_range(1, 30);
      while (chunk_bytes.size() > cut) void'(chunk_bytes.pop_back());
    end
  endtask

  initial begin
    // Reset is held from time zero and released once, at a clock edge.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 32;
    rx_idle_pct = 64;

    // Directed chunks. A normal header, then the same with the enable low.
    put_text("PROXY TCP4 192.168.1.10 10.0.0.1 56324 443");
    put_crlf();
    put_text("GET");
    send_chunk(1'b1);
    put_text("PROXY TCP4 192.168.1.10 10.0.0.1 56324 443");
    put_crlf();
    send_chunk(1'b0);
    // Largest and smallest addresses; the largest fills the whole scan window.
    put_text("PROXY TCP4 255.255.255.255 1.1.1.1 1 2");
    put_crlf();
    send_chunk(1'b1);
    put_text("PROXY TCP4 0.0.0.0 0.0.0.0 0 0");
    put_crlf();
    send_chunk(1'b1);
    // Chunks too short for the prefix, or carrying only the prefix.
    put_text("P");
    send_chunk(1'b1);
    put_text("PROXY");
    send_chunk(1'b1);
    put_text("PROXY ");
    send_chunk(1'b1);
    put_text("PROXY ");
    put_crlf();
    send_chunk(1'b1);
    // Address reported although no CRLF follows.
    put_text("PROXY TCP4 1.2.3.4 5.6.7.8 99");
    send_chunk(1'b1);
    // Chunk ending one byte before the address can count, then just enough.
    put_text("PROXY TCP4 10.20.30.40 56");
    send_chunk(1'b1);
    put_text("PROXY TCP4 10.20.30.40 567");
    send_chunk(1'b1);
    // Broken addresses: leading zero, octet over 255, empty octets, too many
    // dots, digit and value saturation, and a window made of dots only.
    put_text("PROXY TCP4 01.2.3.4 5.6.7.8 1 1");
    put_crlf();
    send_chunk(1'b1);
    put_text("PROXY TCP4 1.2.3.256 5.6.7.8 1 1");
    put_crlf();
    send_chunk(1'b1);
    put_text("PROXY TCP4 1..3.4 5.6.7.8 1 1");
    put_crlf();
    send_chunk(1'b1);
    put_text("PROXY TCP4 1.2.3. 5.6.7.8 1 1");
    put_crlf();
    send_chunk(1'b1);
    put_text("PROXY TCP4 1.2.3.4.5 6.7.8.9 1");
    put_crlf();
    send_chunk(1'b1);
    put_text("PROXY TCP4 9.9.9.00000000000 1");
    put_crlf();
    send_chunk(1'b1);
    put_text("PROXY TCP4 1.2.3.9999999999 1");
    put_crlf();
    send_chunk(1'b1);
    put_text("PROXY TCP4 ............... 1");
    put_crlf();
    send_chunk(1'b1);
    // A zero byte ends the CRLF search; a lone CR does not end a header.
    put_text("PROXY TCP4 1.2.3.4 5.6.7.8 1 2");
    add_byte(CHAR_NUL);
    put_crlf();
    send_chunk(1'b1);
    put_text("PROXY TCP4 1.2.3.4 5.6.7.8 1");
    add_byte(CHAR_CR);
    put_text("x");
    add_byte(CHAR_CR);
    put_crlf();
    send_chunk(1'b1);
    put_text("PROXY TCP6 ::1 ::1 1 2");
    put_crlf();
    send_chunk(1'b1);

    // Random chunks in three idling phases; the long hold-off starts with
    // the phase in which neither side idles.
    while (rand_bytes < RAND_BYTES || rand_chunks < RAND_CHUNKS) begin
      if (rand_bytes < RAND_BYTES / 3) begin
        tx_idle_pct = 32;
        rx_idle_pct = 64;
      end else if (rand_bytes < 2 * RAND_BYTES / 3) begin
        tx_idle_pct = 64;
        rx_idle_pct = 32;
      end else begin
        if (tx_idle_pct != 0) hold_req <= 1'b1;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      build_random_chunk();
      rand_bytes += chunk_bytes.size();
      rand_chunks++;
      send_chunk($urandom_range(99) < 85);
    end
    in_valid  <= 1'b0;
    last_byte <= 1'b0;

    // Drain: wait for every predicted result, then keep watching so that a
    // stray extra result beat would still be caught.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[proxy_v1_header_parser_unit.f]
hdl/pv1hp_pkg.sv
hdl/pv1hp_addr_scan.sv
hdl/proxy_v1_header_parser_unit.sv
test/pv1hp_result_checker.sv
test/tb_proxy_v1_header_parser_unit.sv
